// ----- hdl/qrr_pkg.sv -----
// Shared types and constants for the quadratic real-root solver.
`default_nettype none

package qrr_pkg;

    localparam int ROOT_BITS = 40;

    typedef enum logic [1:0] {
        CASE_NO_REAL = 2'd0,
        CASE_DOUBLE  = 2'd1,
        CASE_TWO     = 2'd2,
        CASE_A_ZERO  = 2'd3
    } t_root_case;

endpackage

`default_nettype wire

// ----- hdl/qrr_disc.sv -----
// Discriminant stages: products, then b*b - 4ac and case selection.
`default_nettype none

module qrr_disc #(
    parameter int CB = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_ce,
    input  wire logic                i_valid,
    input  wire logic signed [CB-1:0] i_a,
    input  wire logic signed [CB-1:0] i_b,
    input  wire logic signed [CB-1:0] i_c,
    output logic                     o_valid,
    output logic [2*CB+1:0]          o_d,
    output logic [2*CB+1:0]          o_side
);
    import qrr_pkg::*;

    localparam int DW = 2 * CB + 2;
    localparam int XW = 2 * CB + 3;

    logic                   r_vld1, r_vld2;
    logic signed [2*CB-1:0] r_bb, r_ac;
    logic signed [CB-1:0]   r_a1, r_b1, r_a2, r_b2;
    logic [DW-1:0]          r_d;
    t_root_case             r_case;

    logic signed [XW-1:0] w_bb, w_ac4, w_d;
    t_root_case           n_case;

    assign w_bb  = XW'(r_bb);
    assign w_ac4 = XW'(r_ac) <<< 2;
    assign w_d   = w_bb - w_ac4;

    always_comb begin
        if (r_a1 == '0) begin
            n_case = CASE_A_ZERO;
        end else if (w_d[XW-1]) begin
            n_case = CASE_NO_REAL;
        end else if (w_d == '0) begin
            n_case = CASE_DOUBLE;
        end else begin
            n_case = CASE_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_ce) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_bb   <= i_b * i_b;
            r_ac   <= i_a * i_c;
            r_a1   <= i_a;
            r_b1   <= i_b;
            r_d    <= w_d[DW-1:0];
            r_case <= n_case;
            r_a2   <= r_a1;
            r_b2   <= r_b1;
        end
    end

    assign o_valid = r_vld2;
    assign o_d     = r_d;
    // side: case, a, b from the lowest bit up
    assign o_side  = {r_b2, r_a2, r_case};

endmodule

`default_nettype wire

// ----- hdl/qrr_sqrt.sv -----
// Pipelined digit-by-digit square root, one root bit per stage.
`default_nettype none

module qrr_sqrt #(
    parameter int DW  = 34,
    parameter int FB  = 16,
    parameter int SBW = 34
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_ce,
    input  wire logic           i_valid,
    input  wire logic [DW-1:0]  i_d,
    input  wire logic [SBW-1:0] i_side,
    output logic                o_valid,
    output logic [DW/2+FB-1:0]  o_root,
    output logic [SBW-1:0]      o_side
);

    localparam int SW   = DW / 2 + FB;
    localparam int RW   = 2 * SW;
    localparam int REMW = SW + 3;

    logic [REMW-1:0] r_rem  [SW];
    logic [SW-1:0]   r_root [SW];
    logic [DW-1:0]   r_d    [SW];
    logic [SBW-1:0]  r_side [SW];
    logic            r_vld  [SW];

    for (genvar i = 0; i < SW; i++) begin : g_stage
        localparam int K = SW - 1 - i;

        logic [REMW-1:0] w_rem_in, w_rem2, w_trial;
        logic [SW-1:0]   w_root_in;
        logic [DW-1:0]   w_d_in;
        logic [SBW-1:0]  w_side_in;
        logic            w_vld_in;
        logic [RW-1:0]   w_rad;

        if (i == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_d_in    = i_d;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[i-1];
            assign w_root_in = r_root[i-1];
            assign w_d_in    = r_d[i-1];
            assign w_side_in = r_side[i-1];
            assign w_vld_in  = r_vld[i-1];
        end

        assign w_rad   = RW'(w_d_in) << (2 * FB);
        assign w_rem2  = (w_rem_in << 2) | REMW'(w_rad[2*K+1 -: 2]);
        assign w_trial = REMW'({w_root_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_ce) begin
                r_vld[i] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_d[i]    <= w_d_in;
                r_side[i] <= w_side_in;
                if (w_rem2 >= w_trial) begin
                    r_rem[i]  <= w_rem2 - w_trial;
                    r_root[i] <= {w_root_in[SW-2:0], 1'b1};
                end else begin
                    r_rem[i]  <= w_rem2;
                    r_root[i] <= {w_root_in[SW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_side  = r_side[SW-1];

endmodule

`default_nettype wire

// ----- hdl/qrr_div.sv -----
// Two-lane pipelined restoring divider, truncating toward zero, with saturation.
`default_nettype none

module qrr_div #(
    parameter int NW   = 35,
    parameter int DENW = 17,
    parameter int SBW  = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_ce,
    input  wire logic                  i_valid,
    input  wire logic signed [NW-1:0]  i_num_p,
    input  wire logic signed [NW-1:0]  i_num_m,
    input  wire logic signed [DENW-1:0] i_den,
    input  wire logic [SBW-1:0]        i_side,
    output logic                       o_valid,
    output logic signed [qrr_pkg::ROOT_BITS-1:0] o_q_p,
    output logic signed [qrr_pkg::ROOT_BITS-1:0] o_q_m,
    output logic [SBW-1:0]             o_side
);
    import qrr_pkg::*;

    localparam int QW = (NW + 1 > ROOT_BITS + 1) ? NW + 1 : ROOT_BITS + 1;
    localparam logic signed [QW-1:0] Q_HI =
        {{(QW - ROOT_BITS + 1){1'b0}}, {(ROOT_BITS - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_LO = ~Q_HI;

    // entry stage
    logic [NW-1:0]   r_mag0 [2];
    logic            r_neg0 [2];
    logic [DENW-1:0] r_dm0;
    logic [SBW-1:0]  r_side0;
    logic            r_vld0;

    // step stages
    logic [NW-1:0]   r_mag  [2][NW];
    logic [DENW-1:0] r_rem  [2][NW];
    logic [NW-1:0]   r_q    [2][NW];
    logic            r_neg  [2][NW];
    logic [DENW-1:0] r_dm   [NW];
    logic [SBW-1:0]  r_side [NW];
    logic            r_vld  [NW];

    // final stage
    logic signed [ROOT_BITS-1:0] r_out [2];
    logic [SBW-1:0]              r_side_f;
    logic                        r_vld_f;

    logic signed [NW-1:0] w_num [2];
    logic [DENW-1:0]      w_dm;

    assign w_num[0] = i_num_p;
    assign w_num[1] = i_num_m;
    assign w_dm     = i_den[DENW-1] ? DENW'(-i_den) : DENW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0  <= 1'b0;
            r_vld_f <= 1'b0;
        end else if (i_ce) begin
            r_vld0  <= i_valid;
            r_vld_f <= r_vld[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_dm0    <= w_dm;
            r_side0  <= i_side;
            r_side_f <= r_side[NW-1];
        end
    end

    for (genvar i = 0; i < NW; i++) begin : g_ctl
        logic [DENW-1:0] w_dm_in;
        logic [SBW-1:0]  w_side_in;
        logic            w_vld_in;

        if (i == 0) begin : g_first
            assign w_dm_in   = r_dm0;
            assign w_side_in = r_side0;
            assign w_vld_in  = r_vld0;
        end else begin : g_next
            assign w_dm_in   = r_dm[i-1];
            assign w_side_in = r_side[i-1];
            assign w_vld_in  = r_vld[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_ce) begin
                r_vld[i] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_dm[i]   <= w_dm_in;
                r_side[i] <= w_side_in;
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [QW-1:0] w_sq, w_sat;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_mag0[l] <= w_num[l][NW-1] ? NW'(-w_num[l]) : NW'(w_num[l]);
                r_neg0[l] <= w_num[l][NW-1] ^ i_den[DENW-1];
            end
        end

        for (genvar i = 0; i < NW; i++) begin : g_step
            localparam int K = NW - 1 - i;

            logic [NW-1:0]   w_mag_in, w_q_in;
            logic [DENW-1:0] w_rem_in, w_dm_in;
            logic            w_neg_in;
            logic [DENW:0]   w_rem2, w_dv;

            if (i == 0) begin : g_first
                assign w_mag_in = r_mag0[l];
                assign w_q_in   = '0;
                assign w_rem_in = '0;
                assign w_neg_in = r_neg0[l];
                assign w_dm_in  = r_dm0;
            end else begin : g_next
                assign w_mag_in = r_mag[l][i-1];
                assign w_q_in   = r_q[l][i-1];
                assign w_rem_in = r_rem[l][i-1];
                assign w_neg_in = r_neg[l][i-1];
                assign w_dm_in  = r_dm[i-1];
            end

            assign w_rem2 = {w_rem_in, w_mag_in[K]};
            assign w_dv   = {1'b0, w_dm_in};

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_mag[l][i] <= w_mag_in;
                    r_neg[l][i] <= w_neg_in;
                    if (w_rem2 >= w_dv) begin
                        r_rem[l][i] <= DENW'(w_rem2 - w_dv);
                        r_q[l][i]   <= {w_q_in[NW-2:0], 1'b1};
                    end else begin
                        r_rem[l][i] <= w_rem2[DENW-1:0];
                        r_q[l][i]   <= {w_q_in[NW-2:0], 1'b0};
                    end
                end
            end
        end

        assign w_sq = r_neg[l][NW-1] ? -$signed(QW'(r_q[l][NW-1]))
                                     : $signed(QW'(r_q[l][NW-1]));

        always_comb begin
            if (w_sq > Q_HI) begin
                w_sat = Q_HI;
            end else if (w_sq < Q_LO) begin
                w_sat = Q_LO;
            end else begin
                w_sat = w_sq;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_out[l] <= w_sat[ROOT_BITS-1:0];
            end
        end
    end

    assign o_valid = r_vld_f;
    assign o_q_p   = r_out[0];
    assign o_q_m   = r_out[1];
    assign o_side  = r_side_f;

endmodule

`default_nettype wire

// ----- hdl/quadratic_real_roots.sv -----
// Top level of the quadratic real-root solver.
// Throughput: one item per cycle; every stage holds while the output item waits.
// Pipeline: discriminant stages, square-root stages (one root bit each), numerator register,
//   divider stages (one quotient bit each) and output register.
// Reset: synchronous, active low; clears all valid bits, so no item is in flight.
`default_nettype none

module quadratic_real_roots #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    output logic       o_s_tready,
    // coef_a, coef_b, coef_c from the lowest bit up
    input  wire logic [((3*COEF_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic       o_m_tvalid,
    input  wire logic  i_m_tready,
    // root_plus, root_minus from the lowest bit up
    output logic [2*qrr_pkg::ROOT_BITS-1:0] o_m_tdata,
    // root_case
    output logic [1:0] o_m_tuser
);
    import qrr_pkg::*;

    localparam int CB   = COEF_BITS;
    localparam int DW   = 2 * CB + 2;
    localparam int SW   = DW / 2 + FRAC_BITS;
    localparam int NW   = CB + FRAC_BITS + 3;
    localparam int DENW = CB + 1;
    localparam int SBW  = 2 + 2 * CB;

    logic w_ce;
    logic w_d_vld, w_s_vld, w_q_vld;
    logic [DW-1:0]  w_d;
    logic [SBW-1:0] w_d_side, w_s_side;
    logic [SW-1:0]  w_root;
    logic [1:0]     w_q_side;
    logic signed [ROOT_BITS-1:0] w_q_p, w_q_m;

    logic signed [CB-1:0] w_sa, w_sb;
    logic signed [NW-1:0] w_base, w_s;

    logic                 r_n_vld;
    logic signed [NW-1:0] r_num_p, r_num_m;
    logic signed [DENW-1:0] r_den;
    logic [1:0]           r_n_case;

    logic                        r_o_vld;
    logic signed [ROOT_BITS-1:0] r_o_p, r_o_m;
    t_root_case                  r_o_case;
    t_root_case                  w_q_case;

    // advance everything unless the output item is held
    assign w_ce       = !r_o_vld || i_m_tready;
    assign o_s_tready = w_ce;

    qrr_disc #(.CB(CB)) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_s_tvalid),
        .i_a     (i_s_tdata[CB-1:0]),
        .i_b     (i_s_tdata[2*CB-1:CB]),
        .i_c     (i_s_tdata[3*CB-1:2*CB]),
        .o_valid (w_d_vld),
        .o_d     (w_d),
        .o_side  (w_d_side)
    );

    qrr_sqrt #(.DW(DW), .FB(FRAC_BITS), .SBW(SBW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_d_vld),
        .i_d     (w_d),
        .i_side  (w_d_side),
        .o_valid (w_s_vld),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    assign w_sa   = w_s_side[2+CB-1:2];
    assign w_sb   = w_s_side[SBW-1:2+CB];
    assign w_base = -(NW'(w_sb) <<< FRAC_BITS);
    assign w_s    = $signed(NW'(w_root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else if (w_ce) begin
            r_n_vld <= w_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_num_p  <= w_base + w_s;
            r_num_m  <= w_base - w_s;
            r_den    <= DENW'(w_sa) <<< 1;
            r_n_case <= w_s_side[1:0];
        end
    end

    qrr_div #(.NW(NW), .DENW(DENW), .SBW(2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_n_vld),
        .i_num_p (r_num_p),
        .i_num_m (r_num_m),
        .i_den   (r_den),
        .i_side  (r_n_case),
        .o_valid (w_q_vld),
        .o_q_p   (w_q_p),
        .o_q_m   (w_q_m),
        .o_side  (w_q_side)
    );

    assign w_q_case = t_root_case'(w_q_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_ce) begin
            r_o_vld <= w_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_o_case <= w_q_case;
            if (w_q_case == CASE_DOUBLE || w_q_case == CASE_TWO) begin
                r_o_p <= w_q_p;
                r_o_m <= w_q_m;
            end else begin
                r_o_p <= '0;
                r_o_m <= '0;
            end
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {r_o_m, r_o_p};
    assign o_m_tuser  = r_o_case;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while output item held");

    a_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == CASE_NO_REAL || o_m_tuser == CASE_A_ZERO)
        |-> o_m_tdata == '0)
        else $error("roots not zero when none exist");

    a_double_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == CASE_DOUBLE |-> r_o_p == r_o_m)
        else $error("double root halves differ");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for quadratic_real_roots: directed and random coefficient sets checked against a predictor.
`timescale 1ns / 100ps

module testbench;
    import qrr_pkg::*;

    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int LATENCY = 2*COEF_BITS + 2*FRAC_BITS + 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_root_case         kind;
        logic signed [39:0] plus;
        logic signed [39:0] minus;
    } t_roots;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    t_roots expected_roots[$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     roots_seen = 0;
    int     cycles = 0;
    int     case_count[4] = '{0, 0, 0, 0};
    bit     random_stall = 1'b1;

    quadratic_real_roots dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] root_sqrt(input logic [63:0] d);
        logic [63:0] rem, root, trial;
        rem = 0;
        root = 0;
        for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
            rem = (rem << 2) | (i >= FRAC_BITS ? ((d >> (2*(i-FRAC_BITS))) & 64'd3) : 64'd0);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic signed [39:0] clamp_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if (q > 64'sd549755813887) q = 64'sd549755813887;
        if (q < -64'sd549755813888) q = -64'sd549755813888;
        return q[39:0];
    endfunction

    function automatic t_roots solve_roots(input logic [15:0] a16, b16, c16);
        t_roots r;
        longint a, b, c, disc, base, s;
        a = longint'(signed'(a16));
        b = longint'(signed'(b16));
        c = longint'(signed'(c16));
        r = '{CASE_NO_REAL, 40'sd0, 40'sd0};
        if (a == 0) begin
            r.kind = CASE_A_ZERO;
            return r;
        end
        disc = b*b - 4*a*c;
        if (disc < 0) return r;
        base = -b * (longint'(1) << FRAC_BITS);
        if (disc == 0) begin
            r.kind = CASE_DOUBLE;
            r.plus = clamp_quot(base, 2*a);
            r.minus = r.plus;
            return r;
        end
        s = longint'(root_sqrt(disc));
        r.kind = CASE_TWO;
        r.plus = clamp_quot(base + s, 2*a);
        r.minus = clamp_quot(base - s, 2*a);
        return r;
    endfunction

    // Hold valid after an accepted item; drop it only when a gap is drawn.
    task automatic send_coefs(input logic [15:0] a, b, c);
        int gap;
        gap = random_stall ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {c, b, a};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_roots.push_back(solve_roots(a, b, c));
        items_sent++;
    endtask

    // Receiver stall: draw a wait per item, then hold ready until it is taken.
    initial begin
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            wait_cycles = random_stall ? $urandom_range(0, 11) : 0;
            if (wait_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_roots want, got;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{t_root_case'(o_m_tuser), o_m_tdata[39:0], o_m_tdata[79:40]};
            roots_seen++;
            if (expected_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
                want = expected_roots.pop_front();
                case_count[want.kind]++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: case %0d/%0d plus %0d/%0d minus %0d/%0d",
                                 want.kind, got.kind, want.plus, got.plus,
                                 want.minus, got.minus);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("quadratic_real_roots test failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_coefs(16'sd0, 16'sd5, -16'sd3);         // leading coefficient zero
        send_coefs(16'sd0, 16'sd0, 16'sd0);
        send_coefs(16'sd1, 16'sd0, 16'sd1);          // negative discriminant
        send_coefs(16'sd1, -16'sd2, 16'sd1);         // double root
        send_coefs(16'sd4, 16'sd4, 16'sd1);
        send_coefs(16'sd1, -16'sd3, 16'sd2);         // two roots
        send_coefs(-16'sd1, 16'sd3, -16'sd2);        // negative a swaps order
        send_coefs(16'sd1, 16'sd0, -16'sd2);
        send_coefs(16'h7fff, 16'h7fff, 16'h8000);
        send_coefs(16'h8000, 16'h8000, 16'h7fff);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h8000, 16'h7fff);
        send_coefs(16'sd1, 16'h8000, 16'h8000);
        send_coefs(-16'sd1, 16'h7fff, 16'h7fff);
        send_coefs(16'h4000, 16'h8000, 16'h4000);    // D = 0 at the edge
        send_coefs(16'hffff, 16'hffff, 16'hffff);
        send_coefs(16'sd1, 16'sd1, 16'sd0);
    endtask

    task automatic test_random(input int count);
        logic [15:0] a, b, c;
        int pick;
        for (int i = 0; i < count; i++) begin
            random_stall = (i % 200) >= 40;
            pick = $urandom_range(0, 9);
            a = 16'($urandom);
            b = 16'($urandom);
            c = 16'($urandom);
            if (pick == 0) begin
                a = '0;
            end else if (pick <= 2) begin
                // perfect square: b even, c = b*b/(4a) with small a
                a = 16'($urandom_range(1, 4));
                b = 16'(2 * int'(a) * int'($urandom_range(0, 90))
                        * ($urandom_range(0, 1) ? 1 : -1));
                c = 16'((longint'(signed'(b)) * longint'(signed'(b))) / (4 * longint'(a)));
                if ($urandom_range(0, 1)) begin
                    a = -a;
                    c = -c;
                end
            end else if (pick <= 4) begin
                a = 16'(int'($urandom_range(0, 40)) - 20);
                b = 16'(int'($urandom_range(0, 400)) - 200);
                c = 16'(int'($urandom_range(0, 400)) - 200);
            end
            send_coefs(a, b, c);
        end
        random_stall = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(800);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_roots.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("Sent %0d coefficient sets, checked %0d results", items_sent, roots_seen);
        $display("Cases: none %0d, double %0d, two %0d, a zero %0d",
                 case_count[0], case_count[1], case_count[2], case_count[3]);
        if (mismatches == 0 && expected_roots.size() == 0) begin
            $display("quadratic_real_roots test passed");
        end else begin
            $display("quadratic_real_roots test failed");
        end
        $finish;
    end
endmodule
